@@ design/wmmcd_pkg.sv @@
// Shared types and constants for the waveform min/max column decimator.
`default_nettype none

package wmmcd_pkg;

   // Fixed formats of the sample and pixel fields.
   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_DIMENSION = 16384;
   localparam int COUNT_BITS    = 31;
   localparam int WIDTH_BITS    = 15;
   localparam int COL_BITS      = 14;
   localparam int HEIGHT_BITS   = 15;
   localparam int CHAN_BITS     = 5;
   localparam int CHANS_BITS    = 6;
   localparam int Y_BITS        = 19;
   localparam int EXT_BITS      = SAMPLE_BITS + 1;
   localparam int PROD_BITS     = Y_BITS + EXT_BITS;
   localparam int BASE_BITS     = Y_BITS + CHAN_BITS;

   localparam logic [CHANS_BITS-1:0] MAX_CHANNELS = 6'd32;
   localparam logic signed [EXT_BITS-1:0] ONE_VALUE = 17'sd32768;
   localparam logic signed [EXT_BITS-1:0] MINUS_ONE = -17'sd32768;

   // The shared divider retires one quotient bit per cycle.
   localparam int DIV_STEPS      = 31;
   localparam int DIV_COUNT_BITS = 5;

   // Result queue between the front and back parts.
   localparam int QUEUE_DEPTH      = 4;
   localparam int QUEUE_PTR_BITS   = 2;
   localparam int QUEUE_COUNT_BITS = 3;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_SAMPLE_COUNT  = 2'd0,
      REG_COLUMN_COUNT  = 2'd1,
      REG_IMAGE_HEIGHT  = 2'd2,
      REG_CHANNEL_COUNT = 2'd3
   } reg_index_type;

   // Setup sequencer states.
   typedef enum logic [1:0] {
      DRV_START,
      DRV_COLS,
      DRV_BAND,
      DRV_READY
   } derive_state_type;

   // Derived setup values handed to the front and back parts.
   typedef struct packed {
      logic                    ready;
      logic                    restart;
      logic [COUNT_BITS-1:0]   quot;
      logic [COL_BITS-1:0]     rem;
      logic [WIDTH_BITS-1:0]   cols;
      logic [CHANS_BITS-1:0]   chans;
      logic [Y_BITS-1:0]       band;
   } derive_type;

   // One closed bin waiting for scaling.
   typedef struct packed {
      logic [COL_BITS-1:0]        column;
      logic [CHAN_BITS-1:0]       channel;
      logic signed [EXT_BITS-1:0] minimum;
      logic signed [EXT_BITS-1:0] maximum;
      logic                       final_column;
   } queue_item_type;

endpackage

`default_nettype wire

@@ design/waveform_min_max_column_decimator.sv @@
// Top level of the waveform min/max column decimator.
//
// Samples enter on the req_ stream in channel-major order, one item per
// cycle. Each channel's samples are split into column bins; when a bin
// closes, one result item leaves on the rsp_ stream with the column, the
// channel and the two line end points in pixels with 4 fraction bits.
// rsp_tlast marks the last column of the last channel.
// Throughput is one item per cycle while req_tready is high. A result
// passes through the queue, the multiply stage and the output register
// before it appears on rsp_.
// After reset and after every csr_ write the setup sequencer runs two
// 31-step divisions on one shared divider; req_tready stays low until
// they finish, and the stream restarts at channel 0, column 0.
// When the receiver stalls, results collect in a four-entry queue, the
// multiply stage and the output register; once the queue is full,
// req_tready drops until the receiver takes items again.
`default_nettype none

module waveform_min_max_column_decimator
   import wmmcd_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // Input stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,    // [15:0] sample_value
   // Result stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,    // [13:0] column_index, [18:14] channel_index,
                                          // [37:19] y_from_minimum, [56:38] y_from_maximum
   output logic             rsp_tlast,    // final_column
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [COUNT_BITS-1:0]   sample_count_ff, sample_count_in;
   logic [WIDTH_BITS-1:0]   column_count_ff, column_count_in;
   logic [HEIGHT_BITS-1:0]  image_height_ff, image_height_in;
   logic [CHANS_BITS-1:0]   channel_count_ff, channel_count_in;

   logic                    cfg_write;
   reg_index_type           cfg_index;
   derive_type              drv;
   logic                    push_valid;
   queue_item_type          push_item;
   logic                    queue_full;
   logic                    queue_empty;
   logic                    pop;
   queue_item_type          pop_item;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_index  = reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      sample_count_in  = sample_count_ff;
      column_count_in  = column_count_ff;
      image_height_in  = image_height_ff;
      channel_count_in = channel_count_ff;
      if (cfg_write) begin
         case (cfg_index)
            REG_SAMPLE_COUNT:  sample_count_in  = csr_pwdata[COUNT_BITS-1:0];
            REG_COLUMN_COUNT:  column_count_in  = csr_pwdata[WIDTH_BITS-1:0];
            REG_IMAGE_HEIGHT:  image_height_in  = csr_pwdata[HEIGHT_BITS-1:0];
            REG_CHANNEL_COUNT: channel_count_in = csr_pwdata[CHANS_BITS-1:0];
            default:           sample_count_in  = sample_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff  <= COUNT_BITS'(1);
         column_count_ff  <= WIDTH_BITS'(1920);
         image_height_ff  <= HEIGHT_BITS'(300);
         channel_count_ff <= CHANS_BITS'(1);
      end else begin
         sample_count_ff  <= sample_count_in;
         column_count_ff  <= column_count_in;
         image_height_ff  <= image_height_in;
         channel_count_ff <= channel_count_in;
      end
   end

   // Register read back.
   always_comb begin
      case (cfg_index)
         REG_SAMPLE_COUNT:  csr_prdata = {{(32-COUNT_BITS){1'b0}}, sample_count_ff};
         REG_COLUMN_COUNT:  csr_prdata = {{(32-WIDTH_BITS){1'b0}}, column_count_ff};
         REG_IMAGE_HEIGHT:  csr_prdata = {{(32-HEIGHT_BITS){1'b0}}, image_height_ff};
         REG_CHANNEL_COUNT: csr_prdata = {{(32-CHANS_BITS){1'b0}}, channel_count_ff};
         default:           csr_prdata = '0;
      endcase
   end

   wmmcd_derive u_derive (
      .clock         (clock),
      .reset         (reset),
      .start         (cfg_write),
      .sample_count  (sample_count_ff),
      .column_count  (column_count_ff),
      .image_height  (image_height_ff),
      .channel_count (channel_count_ff),
      .drv           (drv)
   );

   wmmcd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .drv        (drv),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   wmmcd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .pop_item  (pop_item)
   );

   wmmcd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .band        (drv.band),
      .queue_empty (queue_empty),
      .pop_item    (pop_item),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTHESIS
   // A closed bin never arrives at a full queue.
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !queue_full)
      else $error("closed bin pushed into a full queue");

   // A register write starts setup, so input must stop on the next cycle.
   a_write_stops_input: assert property (@(posedge clock) disable iff (reset)
      cfg_write |=> !req_tready)
      else $error("input still accepted after a register write");
`endif

endmodule

`default_nettype wire

@@ design/wmmcd_derive.sv @@
// Setup sequencer: effective limits, bin quotient and remainder, band height.
`default_nettype none

module wmmcd_derive
   import wmmcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [COUNT_BITS-1:0]  sample_count,
   input  wire logic [WIDTH_BITS-1:0]  column_count,
   input  wire logic [HEIGHT_BITS-1:0] image_height,
   input  wire logic [CHANS_BITS-1:0]  channel_count,
   output derive_type                  drv
);

   derive_state_type            state_ff, state_in;
   logic [COUNT_BITS-1:0]       num_ff, num_in;
   logic [WIDTH_BITS-1:0]       den_ff, den_in;
   logic [WIDTH_BITS-1:0]       part_ff, part_in;
   logic [DIV_COUNT_BITS-1:0]   step_ff, step_in;
   logic [COUNT_BITS-1:0]       quot_ff, quot_in;
   logic [COL_BITS-1:0]         rem_ff, rem_in;
   logic [WIDTH_BITS-1:0]       cols_ff, cols_in;
   logic [CHANS_BITS-1:0]       chans_ff, chans_in;
   logic [Y_BITS-1:0]           band_ff, band_in;
   logic                        restart;

   logic [COUNT_BITS-1:0]       n_eff;
   logic [WIDTH_BITS-1:0]       w_lim;
   logic [WIDTH_BITS-1:0]       w_eff;
   logic [HEIGHT_BITS-1:0]      h_eff;
   logic [CHANS_BITS-1:0]       c_eff;
   logic [WIDTH_BITS:0]         partial;
   logic [WIDTH_BITS:0]         diff;
   logic                        take;
   logic [WIDTH_BITS-1:0]       part_next;
   logic [COUNT_BITS-1:0]       num_next;
   logic                        last_step;

   // Clamp the configuration to the ranges the datapath supports.
   always_comb begin
      n_eff = (sample_count == '0) ? COUNT_BITS'(1) : sample_count;
      w_lim = (column_count == '0) ? WIDTH_BITS'(1) : column_count;
      if (w_lim > WIDTH_BITS'(MAX_DIMENSION)) begin
         w_lim = WIDTH_BITS'(MAX_DIMENSION);
      end
      w_eff = w_lim;
      if ({{(COUNT_BITS-WIDTH_BITS){1'b0}}, w_lim} > n_eff) begin
         w_eff = n_eff[WIDTH_BITS-1:0];
      end
      h_eff = (image_height > HEIGHT_BITS'(MAX_DIMENSION)) ?
              HEIGHT_BITS'(MAX_DIMENSION) : image_height;
      c_eff = (channel_count == '0) ? CHANS_BITS'(1) : channel_count;
      if (c_eff > MAX_CHANNELS) begin
         c_eff = MAX_CHANNELS;
      end
   end

   // One restoring division step.
   assign partial   = {part_ff, num_ff[COUNT_BITS-1]};
   assign diff      = partial - {1'b0, den_ff};
   assign take      = (partial >= {1'b0, den_ff});
   assign part_next = take ? diff[WIDTH_BITS-1:0] : partial[WIDTH_BITS-1:0];
   assign num_next  = {num_ff[COUNT_BITS-2:0], take};
   assign last_step = (step_ff == DIV_COUNT_BITS'(DIV_STEPS - 1));

   // Sequencer: divide samples by columns, then sixteen times height by channels.
   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      part_in  = part_ff;
      step_in  = step_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      cols_in  = cols_ff;
      chans_in = chans_ff;
      band_in  = band_ff;
      restart  = 1'b0;
      case (state_ff)
         DRV_START: begin
            cols_in  = w_eff;
            chans_in = c_eff;
            num_in   = n_eff;
            den_in   = w_eff;
            part_in  = '0;
            step_in  = '0;
            state_in = DRV_COLS;
         end
         DRV_COLS: begin
            num_in  = num_next;
            part_in = part_next;
            step_in = step_ff + DIV_COUNT_BITS'(1);
            if (last_step) begin
               quot_in  = num_next;
               rem_in   = part_next[COL_BITS-1:0];
               num_in   = {{(COUNT_BITS-HEIGHT_BITS-4){1'b0}}, h_eff, 4'b0000};
               den_in   = {{(WIDTH_BITS-CHANS_BITS){1'b0}}, chans_ff};
               part_in  = '0;
               step_in  = '0;
               state_in = DRV_BAND;
            end
         end
         DRV_BAND: begin
            num_in  = num_next;
            part_in = part_next;
            step_in = step_ff + DIV_COUNT_BITS'(1);
            if (last_step) begin
               band_in  = num_next[Y_BITS-1:0];
               restart  = 1'b1;
               state_in = DRV_READY;
            end
         end
         DRV_READY: begin
            state_in = DRV_READY;
         end
         default: begin
            state_in = DRV_START;
         end
      endcase
      if (start) begin
         state_in = DRV_START;
      end
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DRV_START;
      end else begin
         state_ff <= state_in;
      end
   end

   // Divider and result registers.
   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      part_ff  <= part_in;
      step_ff  <= step_in;
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      cols_ff  <= cols_in;
      chans_ff <= chans_in;
      band_ff  <= band_in;
   end

   assign drv.ready   = (state_ff == DRV_READY);
   assign drv.restart = restart;
   assign drv.quot    = quot_ff;
   assign drv.rem     = rem_ff;
   assign drv.cols    = cols_ff;
   assign drv.chans   = chans_ff;
   assign drv.band    = band_ff;

endmodule

`default_nettype wire

@@ design/wmmcd_front.sv @@
// Front part: accepts samples, tracks bin limits and running extremes.
`default_nettype none

module wmmcd_front
   import wmmcd_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire derive_type             drv,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [SAMPLE_BITS-1:0] req_tdata,
   input  wire logic                   queue_full,
   output logic                        push_valid,
   output queue_item_type              push_item
);

   logic [COUNT_BITS-1:0]       left_ff, left_in;
   logic [COL_BITS-1:0]         acc_ff, acc_in;
   logic [COL_BITS-1:0]         col_ff, col_in;
   logic [CHAN_BITS-1:0]        ch_ff, ch_in;
   logic signed [EXT_BITS-1:0]  min_ff, min_in;
   logic signed [EXT_BITS-1:0]  max_ff, max_in;

   logic                        accept;
   logic signed [EXT_BITS-1:0]  sample_ext;
   logic signed [EXT_BITS-1:0]  new_min;
   logic signed [EXT_BITS-1:0]  new_max;
   logic                        close;
   logic                        col_last;
   logic                        ch_last;
   logic [WIDTH_BITS-1:0]       acc_sum;
   logic [WIDTH_BITS-1:0]       acc_less;
   logic                        acc_wrap;

   assign req_tready = drv.ready && !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Running extremes including the incoming item.
   assign sample_ext = {req_tdata[SAMPLE_BITS-1], req_tdata};
   assign new_min    = (sample_ext < min_ff) ? sample_ext : min_ff;
   assign new_max    = (sample_ext > max_ff) ? sample_ext : max_ff;

   // Bin boundary and wrap conditions.
   assign close    = (left_ff == COUNT_BITS'(1));
   assign col_last = (({1'b0, col_ff} + WIDTH_BITS'(1)) == drv.cols);
   assign ch_last  = (({1'b0, ch_ff} + CHANS_BITS'(1)) == drv.chans);
   assign acc_sum  = {1'b0, acc_ff} + {1'b0, drv.rem};
   assign acc_less = acc_sum - drv.cols;
   assign acc_wrap = (acc_sum >= drv.cols);

   // A closing item hands the finished bin to the queue.
   assign push_valid             = accept && close;
   assign push_item.column       = col_ff;
   assign push_item.channel      = ch_ff;
   assign push_item.minimum      = new_min;
   assign push_item.maximum      = new_max;
   assign push_item.final_column = col_last && ch_last;

   // Bin bookkeeping.
   always_comb begin
      left_in = left_ff;
      acc_in  = acc_ff;
      col_in  = col_ff;
      ch_in   = ch_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      if (drv.restart) begin
         left_in = drv.quot;
         acc_in  = drv.rem;
         col_in  = '0;
         ch_in   = '0;
         min_in  = ONE_VALUE;
         max_in  = MINUS_ONE;
      end else if (accept) begin
         if (close) begin
            min_in = ONE_VALUE;
            max_in = MINUS_ONE;
            if (col_last) begin
               col_in  = '0;
               ch_in   = ch_last ? '0 : ch_ff + CHAN_BITS'(1);
               left_in = drv.quot;
               acc_in  = drv.rem;
            end else begin
               col_in = col_ff + COL_BITS'(1);
               if (acc_wrap) begin
                  acc_in  = acc_less[COL_BITS-1:0];
                  left_in = drv.quot + COUNT_BITS'(1);
               end else begin
                  acc_in  = acc_sum[COL_BITS-1:0];
                  left_in = drv.quot;
               end
            end
         end else begin
            left_in = left_ff - COUNT_BITS'(1);
            min_in  = new_min;
            max_in  = new_max;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= COUNT_BITS'(1);
         acc_ff  <= '0;
         col_ff  <= '0;
         ch_ff   <= '0;
         min_ff  <= ONE_VALUE;
         max_ff  <= MINUS_ONE;
      end else begin
         left_ff <= left_in;
         acc_ff  <= acc_in;
         col_ff  <= col_in;
         ch_ff   <= ch_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
      end
   end

endmodule

`default_nettype wire

@@ design/wmmcd_queue.sv @@
// Short queue of closed bins between the front and back parts.
`default_nettype none

module wmmcd_queue
   import wmmcd_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push,
   input  wire queue_item_type push_item,
   output logic                full,
   input  wire logic           pop,
   output logic                empty,
   output queue_item_type      pop_item
);

   queue_item_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]     wr_ff, wr_in;
   logic [QUEUE_PTR_BITS-1:0]     rd_ff, rd_in;
   logic [QUEUE_COUNT_BITS-1:0]   count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign full     = (count_ff == QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_item = slot_ff[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in    = do_push ? wr_ff + QUEUE_PTR_BITS'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + QUEUE_PTR_BITS'(1) : rd_ff;
      count_in = count_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QUEUE_COUNT_BITS'(1);
         2'b01:   count_in = count_ff - QUEUE_COUNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ design/wmmcd_back.sv @@
// Back part: scales bin extremes to pixel coordinates and drives the result channel.
`default_nettype none

module wmmcd_back
   import wmmcd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [Y_BITS-1:0] band,
   input  wire logic              queue_empty,
   input  wire queue_item_type    pop_item,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [63:0]            rsp_tdata,
   output logic                   rsp_tlast
);

   localparam logic [PROD_BITS-1:0] HALF_ROUND = PROD_BITS'(1) << (SAMPLE_BITS - 1);

   // Multiply stage.
   logic                    s1_valid_ff, s1_valid_in;
   logic [PROD_BITS-1:0]    s1_pmin_ff;
   logic [PROD_BITS-1:0]    s1_pmax_ff;
   logic [BASE_BITS-1:0]    s1_base_ff;
   logic [COL_BITS-1:0]     s1_col_ff;
   logic [CHAN_BITS-1:0]    s1_ch_ff;
   logic                    s1_last_ff;

   // Output register.
   logic                    out_valid_ff, out_valid_in;
   logic [COL_BITS-1:0]     out_col_ff;
   logic [CHAN_BITS-1:0]    out_ch_ff;
   logic [Y_BITS-1:0]       out_ymin_ff;
   logic [Y_BITS-1:0]       out_ymax_ff;
   logic                    out_last_ff;

   logic                    s2_ready;
   logic                    s1_adv;
   logic [EXT_BITS:0]       span_min_wide;
   logic [EXT_BITS:0]       span_max_wide;
   logic [EXT_BITS-1:0]     span_min;
   logic [EXT_BITS-1:0]     span_max;
   logic [PROD_BITS-1:0]    pmin;
   logic [PROD_BITS-1:0]    pmax;
   logic [BASE_BITS-1:0]    base;
   logic [PROD_BITS-1:0]    tmin;
   logic [PROD_BITS-1:0]    tmax;
   logic [Y_BITS-1:0]       ymin;
   logic [Y_BITS-1:0]       ymax;

   // Flow control through the two stages.
   assign s2_ready     = !out_valid_ff || rsp_tready;
   assign s1_adv       = !s1_valid_ff || s2_ready;
   assign pop          = !queue_empty && s1_adv;
   assign s1_valid_in  = s1_adv ? !queue_empty : s1_valid_ff;
   assign out_valid_in = s2_ready ? s1_valid_ff : out_valid_ff;

   // Distance of each extreme below full scale, then times the band height; band offset is band height times channel.
   assign span_min_wide = {1'b0, ONE_VALUE} - {pop_item.minimum[EXT_BITS-1], pop_item.minimum};
   assign span_max_wide = {1'b0, ONE_VALUE} - {pop_item.maximum[EXT_BITS-1], pop_item.maximum};
   assign span_min      = span_min_wide[EXT_BITS-1:0];
   assign span_max      = span_max_wide[EXT_BITS-1:0];
   assign pmin          = band * span_min;
   assign pmax          = band * span_max;
   assign base          = band * pop_item.channel;

   // Round half up, drop the sample scale and add the band offset.
   assign tmin = s1_pmin_ff + HALF_ROUND;
   assign tmax = s1_pmax_ff + HALF_ROUND;
   assign ymin = s1_base_ff[Y_BITS-1:0] + tmin[SAMPLE_BITS +: Y_BITS];
   assign ymax = s1_base_ff[Y_BITS-1:0] + tmax[SAMPLE_BITS +: Y_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_pmin_ff <= pmin;
         s1_pmax_ff <= pmax;
         s1_base_ff <= base;
         s1_col_ff  <= pop_item.column;
         s1_ch_ff   <= pop_item.channel;
         s1_last_ff <= pop_item.final_column;
      end
      if (s2_ready && s1_valid_ff) begin
         out_col_ff  <= s1_col_ff;
         out_ch_ff   <= s1_ch_ff;
         out_ymin_ff <= ymin;
         out_ymax_ff <= ymax;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(64 - COL_BITS - CHAN_BITS - 2 * Y_BITS){1'b0}},
                        out_ymax_ff, out_ymin_ff, out_ch_ff, out_col_ff};

endmodule

`default_nettype wire

@@ tb/waveform_min_max_column_decimator_tb.sv @@
// Self-checking testbench for the waveform min/max column decimator.
`default_nettype none

module waveform_min_max_column_decimator_tb
   import wmmcd_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FULL_SCALE    = 1 << (SAMPLE_BITS - 1);
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 300;
   localparam int WIDE_ITEMS    = 32;
   localparam int PRESSURE_ITEMS = 32;
   localparam longint CYCLE_LIMIT = 400000;

   // One expected column line, as the block reports it.
   typedef struct packed {
      logic [COL_BITS-1:0]  column_index;
      logic [CHAN_BITS-1:0] channel_index;
      logic [Y_BITS-1:0]    y_from_minimum;
      logic [Y_BITS-1:0]    y_from_maximum;
      logic                 final_column;
   } column_line_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   waveform_min_max_column_decimator dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock, 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stimulus and checking bookkeeping.
   logic [15:0]     sample_backlog[$];
   column_line_type expected_lines[$];
   int              error_count = 0;
   longint          cycle_count = 0;
   int              samples_accepted = 0;
   int              lines_checked = 0;
   int              settings_applied = 0;
   int              send_idle_pct = 0;
   int              recv_stall_pct = 0;
   logic            req_taken = 1'b0;
   logic            rsp_hold = 1'b0;
   logic            start_hold = 1'b0;

   // Register copies and the derived bin geometry of the predictor.
   logic [COUNT_BITS-1:0]  sample_count_reg;
   logic [WIDTH_BITS-1:0]  column_count_reg;
   logic [HEIGHT_BITS-1:0] image_height_reg;
   logic [CHANS_BITS-1:0]  channel_count_reg;
   longint unsigned eff_samples, eff_cols, eff_chans, quot, rem, band_height;
   longint unsigned sample_pos, column_pos, channel_pos, bin_end, rem_acc;
   int              bin_minimum, bin_maximum;

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic restart_bins();
      sample_pos  = 0;
      column_pos  = 0;
      bin_end     = quot;
      rem_acc     = rem;
      bin_minimum = FULL_SCALE;
      bin_maximum = -FULL_SCALE;
   endtask

   // Clamp the registers into a usable geometry and restart the stream.
   task automatic derive_geometry();
      longint unsigned n, w, h, c;
      n = (sample_count_reg == 0) ? 1 : sample_count_reg;
      w = (column_count_reg == 0) ? 1 : column_count_reg;
      h = image_height_reg;
      c = (channel_count_reg == 0) ? 1 : channel_count_reg;
      if (w > MAX_DIMENSION) w = MAX_DIMENSION;
      if (w > n) w = n;
      if (h > MAX_DIMENSION) h = MAX_DIMENSION;
      if (c > MAX_CHANNELS) c = MAX_CHANNELS;
      eff_samples = n;
      eff_cols    = w;
      eff_chans   = c;
      quot        = n / w;
      rem         = n % w;
      band_height = (16 * h) / c;
      channel_pos = 0;
      restart_bins();
   endtask

   task automatic load_register(input reg_index_type idx, input logic [31:0] value);
      case (idx)
         REG_SAMPLE_COUNT:  sample_count_reg  = value[COUNT_BITS-1:0];
         REG_COLUMN_COUNT:  column_count_reg  = value[WIDTH_BITS-1:0];
         REG_IMAGE_HEIGHT:  image_height_reg  = value[HEIGHT_BITS-1:0];
         REG_CHANNEL_COUNT: channel_count_reg = value[CHANS_BITS-1:0];
         default: ;
      endcase
      derive_geometry();
   endtask

   // Line end for one extreme: band offset plus band middle minus extreme times half band, rounded half up.
   function automatic logic [Y_BITS-1:0] line_end(input int extreme);
      longint unsigned span, scaled;
      span   = longint'(FULL_SCALE - extreme);
      scaled = band_height * span + FULL_SCALE;
      return Y_BITS'(channel_pos * band_height + (scaled >> SAMPLE_BITS));
   endfunction

   // Fold one sample into the current bin and queue a line when the bin closes.
   task automatic bin_sample(input logic signed [15:0] sample);
      column_line_type line;
      int value;
      value = sample;
      if (value < bin_minimum) bin_minimum = value;
      if (value > bin_maximum) bin_maximum = value;
      sample_pos++;
      if (sample_pos == bin_end) begin
         line.column_index   = COL_BITS'(column_pos);
         line.channel_index  = CHAN_BITS'(channel_pos);
         line.y_from_minimum = line_end(bin_minimum);
         line.y_from_maximum = line_end(bin_maximum);
         line.final_column   = (column_pos + 1 == eff_cols) && (channel_pos + 1 == eff_chans);
         expected_lines.push_back(line);
         bin_minimum = FULL_SCALE;
         bin_maximum = -FULL_SCALE;
         column_pos++;
         if (column_pos >= eff_cols) begin
            channel_pos++;
            if (channel_pos >= eff_chans) channel_pos = 0;
            restart_bins();
         end else begin
            rem_acc += rem;
            bin_end += quot;
            if (rem_acc >= eff_cols) begin
               rem_acc -= eff_cols;
               bin_end++;
            end
         end
      end
   endtask

   // Sample driver: holds an item until it is taken, then offers the next one.
   always @(negedge clock) begin : drive_samples
      logic        next_valid;
      logic [15:0] next_data;
      next_valid = 1'b0;
      next_data  = req_tdata;
      if (reset) begin
         next_valid = 1'b0;
      end else if (req_tvalid && !req_taken) begin
         next_valid = 1'b1;
      end else if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
         next_valid = 1'b1;
         next_data  = sample_backlog.pop_front();
      end
      req_tvalid <= next_valid;
      req_tdata  <= next_data;
   end

   // Result receiver: random stalls, plus the long hold-off when requested.
   always @(negedge clock) begin
      rsp_tready <= !reset && !rsp_hold && ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Monitor: predicts on every accepted sample and checks every accepted line.
   always @(posedge clock) begin : watch_streams
      column_line_type want;
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d lines outstanding",
                  cycle_count, expected_lines.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         if (!reset && rsp_tvalid && rsp_tready) begin
            lines_checked++;
            if (expected_lines.size() == 0) begin
               report_mismatch($sformatf("unexpected line, tdata %h", rsp_tdata));
            end else begin
               want = expected_lines.pop_front();
               if (rsp_tdata[13:0] != want.column_index)
                  report_mismatch($sformatf("column_index %0d, expected %0d",
                                            rsp_tdata[13:0], want.column_index));
               if (rsp_tdata[18:14] != want.channel_index)
                  report_mismatch($sformatf("channel_index %0d, expected %0d",
                                            rsp_tdata[18:14], want.channel_index));
               if (rsp_tdata[37:19] != want.y_from_minimum)
                  report_mismatch($sformatf("y_from_minimum %0d, expected %0d",
                                            rsp_tdata[37:19], want.y_from_minimum));
               if (rsp_tdata[56:38] != want.y_from_maximum)
                  report_mismatch($sformatf("y_from_maximum %0d, expected %0d",
                                            rsp_tdata[56:38], want.y_from_maximum));
               if (rsp_tdata[63:57] != '0)
                  report_mismatch($sformatf("tdata pad bits %h not zero", rsp_tdata[63:57]));
               if (rsp_tlast != want.final_column)
                  report_mismatch($sformatf("final_column %0d, expected %0d",
                                            rsp_tlast, want.final_column));
            end
         end
         req_taken = !reset && req_tvalid && req_tready;
         if (req_taken) begin
            samples_accepted++;
            bin_sample(req_tdata);
         end
      end
   end

   // Long receiver hold-off while samples keep coming, to back the block up.
   initial begin
      wait (start_hold);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Two-phase register write; the predictor takes the value at the access edge.
   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      load_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic apply_setting(input logic [31:0] n, input logic [31:0] w,
                                input logic [31:0] h, input logic [31:0] c);
      csr_write(REG_SAMPLE_COUNT, n);
      csr_write(REG_COLUMN_COUNT, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_CHANNEL_COUNT, c);
      settings_applied++;
   endtask

   // Wait for all samples to go in and all lines to come out, then let the block settle.
   task automatic wait_for_quiet();
      @(posedge clock);
      while (sample_backlog.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_lines.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random sample with extra weight on full scale.
   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Main sequence: reset, directed cases, random settings, one widest frame.
   initial begin : run_sequence
      logic [31:0] n, w, h, c;
      int random_sent, frame_len, count;
      sample_count_reg  = 31'd1;
      column_count_reg  = 15'd1920;
      image_height_reg  = 15'd300;
      channel_count_reg = 6'd1;
      derive_geometry();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset geometry: one sample per column, full-scale extremes.
      sample_backlog = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
      wait_for_quiet();
      // Zero sample, column and channel counts, zero height.
      apply_setting(0, 0, 0, 0);
      sample_backlog = '{16'h0001, 16'h8000};
      wait_for_quiet();
      // Too many columns and channels, oversized height.
      apply_setting(3, 32767, 32767, 63);
      sample_backlog = '{16'h7FFF, 16'h8000, 16'h1234, 16'hEDCB, 16'h0000, 16'h7FFF};
      wait_for_quiet();
      // Largest sample count: bins never close here.
      apply_setting(32'h7FFF_FFFF, 1, 1, 1);
      sample_backlog = '{16'h5555, 16'hAAAA, 16'h0F0F};
      wait_for_quiet();
      // Uneven bins over two channels, running through the frame wrap.
      apply_setting(5, 2, 16384, 2);
      sample_backlog = '{16'h8000, 16'h7FFF, 16'h0100, 16'hFF00, 16'h0001,
                         16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0000};
      wait_for_quiet();
      // One column per sample while the receiver holds off: the block fills and stalls.
      apply_setting(PRESSURE_ITEMS, PRESSURE_ITEMS, 100, 1);
      start_hold = 1'b1;
      repeat (PRESSURE_ITEMS) sample_backlog.push_back(pick_sample());
      wait_for_quiet();

      // Random settings, mostly whole frames, some cut short.
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (random_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct  = 30;
            recv_stall_pct = 83;
         end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 83;
            recv_stall_pct = 30;
         end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         if ($urandom_range(0, 19) == 0) n = 0;
         if (n > 16) begin
            c = 1;
         end else if (n <= 2 && $urandom_range(0, 3) == 0) begin
            case ($urandom_range(0, 2))
               0: c = 32;
               1: c = 33;
               default: c = 63;
            endcase
         end else begin
            c = $urandom_range(0, 4);
         end
         case ($urandom_range(0, 9))
            0: w = 32767;
            1: w = 16384;
            2: w = 0;
            default: w = $urandom_range(1, n + 1);
         endcase
         case ($urandom_range(0, 7))
            0: h = 0;
            1: h = 32767;
            2: h = 16384;
            3: h = 1;
            default: h = $urandom_range(2, 16383);
         endcase
         apply_setting(n, w, h, c);
         frame_len = int'(eff_samples * eff_chans);
         if ($urandom_range(0, 4) == 0)
            count = $urandom_range(1, 2 * frame_len);
         else
            count = frame_len * ((frame_len <= 20) ? $urandom_range(1, 3) : 1);
         repeat (count) sample_backlog.push_back(pick_sample());
         random_sent += count;
         wait_for_quiet();
      end

      // Widest image, cut short after its first columns.
      apply_setting(MAX_DIMENSION, MAX_DIMENSION, $urandom_range(1, 16384), 1);
      repeat (WIDE_ITEMS) sample_backlog.push_back(pick_sample());
      wait_for_quiet();

      $display("Covered %0d register settings: %0d samples in, %0d column lines checked.",
               settings_applied, samples_accepted, lines_checked);
      $display("Idle mixes: sender-light, receiver-light and none, plus a %0d-cycle hold-off.",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
design/wmmcd_pkg.sv
design/wmmcd_derive.sv
design/wmmcd_front.sv
design/wmmcd_queue.sv
design/wmmcd_back.sv
design/waveform_min_max_column_decimator.sv
tb/waveform_min_max_column_decimator_tb.sv
